/* hdl/swrb_pkg.sv */
// Shared constants, function codes and controller command type for the reorder buffer.
package swrb_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int INDEX_BITS   = 32;
   localparam int FUNC_BITS    = 2;
   localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);

   localparam logic [SLOT_BITS:0]    DEPTH_SUM  = (SLOT_BITS + 1)'(WINDOW_DEPTH);
   localparam logic [SLOT_BITS-1:0]  LAST_SLOT  = SLOT_BITS'(WINDOW_DEPTH - 1);
   localparam logic [INDEX_BITS-1:0] DEPTH_IDX  = INDEX_BITS'(WINDOW_DEPTH);

   localparam logic [FUNC_BITS-1:0] FUNC_GET    = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_PUT    = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_POP    = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_POP_IF = 2'd3;

   typedef struct packed {
      logic capture;
      logic access;
   } swrb_cmd_type;

endpackage

/* hdl/swrb_ctrl.sv */
// Controller state machine that sequences capture, slot access and result hand-off.
module swrb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output swrb_pkg::swrb_cmd_type cmd
);
   import swrb_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ACCESS = 2'd1;
   localparam logic [1:0] ST_RESP   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.access  = (state_ff == ST_ACCESS);

   a_resp_after_access: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_ACCESS))
      else $error("result raised without a slot access");

   a_capture_to_access: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.access)
      else $error("captured item not followed by access");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid || cmd.access) |-> req_stall)
      else $error("input open while an item is in flight");

endmodule

/* hdl/swrb_dp.sv */
// Datapath: captured item, slot ring storage, present bits, head and base pointers.
module swrb_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swrb_pkg::swrb_cmd_type               cmd,
   input  logic [swrb_pkg::FUNC_BITS-1:0]       req_func,
   input  logic [swrb_pkg::INDEX_BITS-1:0]      req_seq_index,
   input  logic [swrb_pkg::PAYLOAD_BITS-1:0]    req_payload,
   input  logic                                 req_payload_present,
   output logic [swrb_pkg::PAYLOAD_BITS-1:0]    rsp_out_payload,
   output logic                                 rsp_out_present,
   output logic                                 rsp_in_window,
   output logic                                 rsp_popped,
   output logic [swrb_pkg::INDEX_BITS-1:0]      rsp_base_index
);
   import swrb_pkg::*;

   logic [FUNC_BITS-1:0]    func_ff;
   logic [INDEX_BITS-1:0]   index_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic                    pres_ff;

   logic [SLOT_BITS-1:0]    head_ff;
   logic [SLOT_BITS-1:0]    head_in;
   logic [INDEX_BITS-1:0]   base_ff;
   logic [INDEX_BITS-1:0]   base_in;
   logic [WINDOW_DEPTH-1:0] present_ff;
   logic [WINDOW_DEPTH-1:0] present_in;

   logic [PAYLOAD_BITS-1:0] rd_data_ff;
   logic                    rd_pres_ff;
   logic                    inside_ff;
   logic                    popped_ff;

   logic [PAYLOAD_BITS-1:0] slot_mem [WINDOW_DEPTH];

   logic [INDEX_BITS-1:0]   offset;
   logic                    in_win;
   logic [SLOT_BITS:0]      slot_sum;
   logic [SLOT_BITS-1:0]    slot;
   logic                    is_rw;
   logic                    pop_go;
   logic                    put_go;
   logic [SLOT_BITS-1:0]    addr;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         index_ff   <= req_seq_index;
         payload_ff <= req_payload;
         pres_ff    <= req_payload_present;
      end
   end

   always_comb begin
      offset   = index_ff - base_ff;
      in_win   = (offset < DEPTH_IDX);
      slot_sum = {1'b0, head_ff} + {1'b0, offset[SLOT_BITS-1:0]};
      if (slot_sum >= DEPTH_SUM) begin
         slot_sum = slot_sum - DEPTH_SUM;
      end
      slot   = slot_sum[SLOT_BITS-1:0];
      is_rw  = (func_ff == FUNC_GET) || (func_ff == FUNC_PUT);
      pop_go = (func_ff == FUNC_POP) || ((func_ff == FUNC_POP_IF) && present_ff[head_ff]);
      put_go = (func_ff == FUNC_PUT) && in_win;
      addr   = is_rw ? slot : head_ff;
   end

   always_comb begin
      present_in = present_ff;
      head_in    = head_ff;
      base_in    = base_ff;
      if (cmd.access) begin
         if (put_go) begin
            present_in[slot] = pres_ff;
         end
         if (pop_go) begin
            present_in[head_ff] = 1'b0;
            head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
            base_in = base_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         head_ff    <= '0;
         base_ff    <= '0;
      end else begin
         present_ff <= present_in;
         head_ff    <= head_in;
         base_ff    <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.access) begin
         rd_data_ff <= slot_mem[addr];
         rd_pres_ff <= present_ff[addr];
         inside_ff  <= in_win;
         popped_ff  <= pop_go;
         if (put_go) begin
            slot_mem[addr] <= payload_ff;
         end
      end
   end

   assign rsp_out_present = rd_pres_ff && (((func_ff == FUNC_GET) && inside_ff) || popped_ff);
   assign rsp_out_payload = rsp_out_present ? rd_data_ff : '0;
   assign rsp_in_window   = inside_ff && is_rw;
   assign rsp_popped      = popped_ff;
   assign rsp_base_index  = base_ff;

   a_base_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.access && pop_go) |=> (base_ff == $past(base_ff) + 1'b1))
      else $error("window base did not advance on pop");

   a_head_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.access && pop_go) |=> !present_ff[$past(head_ff)])
      else $error("popped head slot still present");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.access |=> ($stable(base_ff) && $stable(head_ff) && $stable(present_ff)))
      else $error("window state changed outside an access");

endmodule

/* hdl/sliding_window_reorder_buffer_core.sv */
// Top level of the sliding-window receive reorder buffer.
//
// The request channel (req_) carries one item: a function code, an absolute
// sequence index, a payload and a present flag. The response channel (rsp_)
// returns exactly one item per request with the slot payload, its present
// flag, the window hit flag, the pop flag and the window base after the item.
// An item is taken when valid is high and stall is low on its channel.
// The block works on one item at a time. An accepted item is captured into
// the input registers and the controller moves from idle to the access
// state, then to the response state, where the response is valid until it
// is taken; req_stall is high in every state but idle, so the next request
// is taken only once the block is back in idle. The slot storage is read
// and written in the access state, and its registered read data feeds the response.
// While the response is stalled it holds steady and req_stall stays high.
// Reset empties every slot and sets the window base and head pointer to
// zero; it takes effect at once with no clearing pass.
module sliding_window_reorder_buffer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [swrb_pkg::FUNC_BITS-1:0]    req_func,
   input  logic [swrb_pkg::INDEX_BITS-1:0]   req_seq_index,
   input  logic [swrb_pkg::PAYLOAD_BITS-1:0] req_payload,
   input  logic                              req_payload_present,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [swrb_pkg::PAYLOAD_BITS-1:0] rsp_out_payload,
   output logic                              rsp_out_present,
   output logic                              rsp_in_window,
   output logic                              rsp_popped,
   output logic [swrb_pkg::INDEX_BITS-1:0]   rsp_base_index
);
   import swrb_pkg::*;

   swrb_cmd_type cmd;

   swrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   swrb_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_func            (req_func),
      .req_seq_index       (req_seq_index),
      .req_payload         (req_payload),
      .req_payload_present (req_payload_present),
      .rsp_out_payload     (rsp_out_payload),
      .rsp_out_present     (rsp_out_present),
      .rsp_in_window       (rsp_in_window),
      .rsp_popped          (rsp_popped),
      .rsp_base_index      (rsp_base_index)
   );

endmodule
